FILE: rtl/core/dbsa_pkg.sv
// Shared types, codes and field widths of the draw batch slot allocator.
package dbsa_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int MAX_QUADS_DEF  = 256;
    localparam int VERTS_PER_QUAD = 4;

    localparam int KEY_W      = 16;
    localparam int QUAD_W     = 9;
    localparam int SLOT_W     = 3;
    localparam int VBASE_W    = 10;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [1:0] {
        F_ACQUIRE   = 2'd0,
        F_RELEASE   = 2'd1,
        F_FLUSH_ALL = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        K_GRANT = 2'd0,
        K_FLUSH = 2'd1,
        K_DONE  = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SEARCH  = 8'b0000_0010,
        ST_APPLY   = 8'b0000_0100,
        ST_GRANT   = 8'b0000_1000,
        ST_RELEASE = 8'b0001_0000,
        ST_FLALL   = 8'b0010_0000,
        ST_DONE    = 8'b0100_0000,
        ST_ERROR   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] material;
        logic [KEY_W-1:0] frame;
        logic [KEY_W-1:0] flags;
    } t_key;

    // search wave control moving down the row of slots
    typedef struct packed {
        logic live;
        logic hit;
    } t_wave;

    // slot write strobes from the sequencer
    typedef struct packed {
        logic key_en;
        logic quads_en;
    } t_wr;

endpackage

FILE: rtl/core/dbsa_cell.sv
// One batch slot: key and quad count, plus its stage of the search wave.
module dbsa_cell
    import dbsa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_QUADS = MAX_QUADS_DEF,
    parameter int IDX       = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_key                                      i_key,
    input  t_wave                                     i_wave,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_wave_idx,
    input  logic [$clog2(MAX_QUADS + 1)-1:0]          i_wave_q,
    output t_wave                                     o_wave,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_wave_idx,
    output logic [$clog2(MAX_QUADS + 1)-1:0]          o_wave_q,
    input  t_wr                                       i_wr,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_wr_idx,
    input  logic [$clog2(MAX_QUADS + 1)-1:0]          i_wr_quads,
    output t_key                                      o_key,
    output logic [$clog2(MAX_QUADS + 1)-1:0]          o_quads
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = $clog2(MAX_QUADS + 1);

    logic          r_valid;
    t_key          r_key;
    logic [QW-1:0] r_quads;

    t_wave         r_wave;
    t_wave         n_wave;
    logic [IW-1:0] r_wave_idx;
    logic [IW-1:0] n_wave_idx;
    logic [QW-1:0] r_wave_q;
    logic [QW-1:0] n_wave_q;

    logic          w_sel;
    logic          w_match;

    assign w_sel   = (i_wr_idx == IW'(IDX));
    assign w_match = r_valid && (r_key == i_key);

    // first match from the top wins; otherwise keep the fullest, ties to the higher slot
    always_comb begin
        n_wave     = i_wave;
        n_wave_idx = i_wave_idx;
        n_wave_q   = i_wave_q;
        if (!i_wave.hit) begin
            if (w_match) begin
                n_wave.hit = 1'b1;
                n_wave_idx = IW'(IDX);
            end else if (r_quads > i_wave_q) begin
                n_wave_idx = IW'(IDX);
                n_wave_q   = r_quads;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_key   <= '0;
            r_quads <= '0;
            r_wave  <= '0;
        end else begin
            r_wave <= n_wave;
            if (w_sel && i_wr.key_en) begin
                r_valid <= 1'b1;
                r_key   <= i_key;
            end
            if (w_sel && i_wr.quads_en) begin
                r_quads <= i_wr_quads;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave_idx <= n_wave_idx;
        r_wave_q   <= n_wave_q;
    end

    assign o_wave     = r_wave;
    assign o_wave_idx = r_wave_idx;
    assign o_wave_q   = r_wave_q;
    assign o_key      = r_key;
    assign o_quads    = r_quads;

endmodule

FILE: rtl/core/draw_batch_slot_allocator_top.sv
// Top level of the draw batch slot allocator: request sequencer, slot row and result register.
//
// Usage
//   Requests enter on the s_axis channel, one per handshake: acquire quads for a key,
//   release quads from a slot, or flush every slot. Results leave on m_axis; tuser
//   carries the result kind (grant/ack, flush record, flush-all done, error) and tlast
//   marks the final result of a request. A request may yield several results (flush
//   records before a grant, or one record per non-empty slot on flush-all).
//   Sequence: an acquire sends a search wave down the row of SLOTS slot cells, one cell
//   per cycle, then passes the apply and grant states, with or without a spill flush.
//   A release or an error issues its result from one state; flush-all walks every slot
//   and then issues the done result. A full output register stalls the sequencer.
//   The next request is taken once the previous one has issued its last result into
//   the output register, even while that result still waits to be taken.
//   Reset (i_rst_n low, synchronous) empties all slots, clears keys and counts and
//   drops any pending result.
//   When the receiver holds m_axis_tready low the result register holds its content
//   and the sequencer waits before issuing the next result; no result is lost.
module draw_batch_slot_allocator_top
    import dbsa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_QUADS = MAX_QUADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[1:0], material_id[17:2], frame_index[33:18], render_flags[49:34],
    // quad_count[58:50], slot_select[61:59], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot[2:0], out_material[18:3], out_frame[34:19], out_flags[50:35],
    // out_quads[59:51], vertex_base[69:60], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = $clog2(MAX_QUADS + 1);
    localparam int AW = ((QW > QUAD_W) ? QW : QUAD_W) + 1;
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int PAD_W = OUT_DATA_W - (SLOT_W + 3 * KEY_W + QUAD_W + VBASE_W);

    // ---------------------------------------------------------------- request fields
    t_func             in_func;
    t_key              in_key;
    logic [QUAD_W-1:0] in_qc;
    logic [SLOT_W-1:0] in_sel;
    logic              in_accept;

    assign in_func         = t_func'(s_axis_tdata[1:0]);
    assign in_key.material = s_axis_tdata[17:2];
    assign in_key.frame    = s_axis_tdata[33:18];
    assign in_key.flags    = s_axis_tdata[49:34];
    assign in_qc           = s_axis_tdata[58:50];
    assign in_sel          = s_axis_tdata[61:59];
    assign in_accept       = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- state
    t_state            r_state;
    t_state            n_state;
    logic              r_inj;
    logic              n_inj;
    t_key              r_key;
    logic [QUAD_W-1:0] r_qc;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic              r_hit;
    logic              n_hit;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_kind                 r_out_kind;
    logic                  r_out_last;

    // ---------------------------------------------------------------- slot row
    t_wave         w_wave [SLOTS+1];
    logic [IW-1:0] w_widx [SLOTS+1];
    logic [QW-1:0] w_wq   [SLOTS+1];
    t_key          c_key  [SLOTS];
    logic [QW-1:0] c_quads[SLOTS];

    t_wr           wr_ctl;
    logic [QW-1:0] wr_quads;

    // inject the wave above the top slot in the same cycle that the latched key appears
    assign w_wave[SLOTS] = '{live: r_inj, hit: 1'b0};
    assign w_widx[SLOTS] = '0;
    assign w_wq[SLOTS]   = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        dbsa_cell #(
            .SLOTS     (SLOTS),
            .MAX_QUADS (MAX_QUADS),
            .IDX       (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_key),
            .i_wave     (w_wave[g+1]),
            .i_wave_idx (w_widx[g+1]),
            .i_wave_q   (w_wq[g+1]),
            .o_wave     (w_wave[g]),
            .o_wave_idx (w_widx[g]),
            .o_wave_q   (w_wq[g]),
            .i_wr       (wr_ctl),
            .i_wr_idx   (r_idx),
            .i_wr_quads (wr_quads),
            .o_key      (c_key[g]),
            .o_quads    (c_quads[g])
        );
    end

    // ---------------------------------------------------------------- selected slot
    t_key             rd_key;
    logic [QW-1:0]    rd_quads;
    logic [AW-1:0]    qc_a;
    logic [AW-1:0]    rd_a;
    logic [AW-1:0]    sum_a;
    logic [AW-1:0]    rel_a;
    logic [AW+1:0]    vb_a;
    logic             over;
    logic             need_flush;
    logic [XW-1:0]    idx_x;
    logic [SLOT_W-1:0] idx_slot;
    logic             out_free;

    assign rd_key   = c_key[r_idx];
    assign rd_quads = c_quads[r_idx];
    assign qc_a     = AW'(r_qc);
    assign rd_a     = AW'(rd_quads);
    assign sum_a    = qc_a + rd_a;
    assign rel_a    = rd_a - qc_a;
    assign vb_a     = (AW+2)'(rd_a) * (AW+2)'(VERTS_PER_QUAD);
    assign over     = (sum_a > AW'(MAX_QUADS));
    // a spill flushes a non-empty victim; a hit flushes only when the grant overflows
    assign need_flush = r_hit ? over : (rd_quads != '0);
    assign idx_x    = XW'(r_idx);
    assign idx_slot = idx_x[SLOT_W-1:0];
    assign out_free = !r_out_valid || m_axis_tready;

    // ---------------------------------------------------------------- result to issue
    logic              emit;
    t_kind             e_kind;
    logic [SLOT_W-1:0] e_slot;
    t_key              e_key;
    logic [QUAD_W-1:0] e_quads;
    logic [VBASE_W-1:0] e_vb;
    logic              e_last;

    always_comb begin
        n_state  = r_state;
        n_inj    = 1'b0;
        n_idx    = r_idx;
        n_hit    = r_hit;
        emit     = 1'b0;
        e_kind   = K_ERROR;
        e_slot   = '0;
        e_key    = '0;
        e_quads  = '0;
        e_vb     = '0;
        e_last   = 1'b1;
        wr_ctl   = '0;
        wr_quads = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_func)
                        F_ACQUIRE: begin
                            if (AW'(in_qc) > AW'(MAX_QUADS)) begin
                                n_state = ST_ERROR;
                            end else begin
                                n_state = ST_SEARCH;
                                n_inj   = 1'b1;
                            end
                        end
                        F_RELEASE: begin
                            if (32'(in_sel) >= 32'(SLOTS)) begin
                                n_state = ST_ERROR;
                            end else begin
                                n_idx   = IW'(in_sel);
                                n_state = ST_RELEASE;
                            end
                        end
                        F_FLUSH_ALL: begin
                            n_idx   = IW'(SLOTS - 1);
                            n_state = ST_FLALL;
                        end
                        default: begin
                            n_state = ST_ERROR;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                // wait for the wave to leave the bottom slot
                if (w_wave[0].live) begin
                    n_hit   = w_wave[0].hit;
                    n_idx   = w_widx[0];
                    n_state = ST_APPLY;
                end
            end

            ST_APPLY: begin
                if (need_flush) begin
                    if (out_free) begin
                        emit           = 1'b1;
                        e_kind         = K_FLUSH;
                        e_slot         = idx_slot;
                        e_key          = rd_key;
                        e_quads        = rd_a[QUAD_W-1:0];
                        e_last         = 1'b0;
                        wr_ctl.quads_en = 1'b1;
                        wr_ctl.key_en  = !r_hit;
                        n_state        = ST_GRANT;
                    end
                end else begin
                    wr_ctl.key_en = !r_hit;
                    n_state       = ST_GRANT;
                end
            end

            ST_GRANT: begin
                if (out_free) begin
                    emit            = 1'b1;
                    e_kind          = K_GRANT;
                    e_slot          = idx_slot;
                    e_key           = rd_key;
                    e_quads         = sum_a[QUAD_W-1:0];
                    e_vb            = (r_qc == '0) ? '0 : vb_a[VBASE_W-1:0];
                    wr_ctl.quads_en = 1'b1;
                    wr_quads        = QW'(sum_a);
                    n_state         = ST_IDLE;
                end
            end

            ST_RELEASE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                    if (qc_a <= rd_a) begin
                        e_kind          = K_GRANT;
                        e_slot          = idx_slot;
                        e_key           = rd_key;
                        e_quads         = rel_a[QUAD_W-1:0];
                        wr_ctl.quads_en = 1'b1;
                        wr_quads        = QW'(rel_a);
                    end
                end
            end

            ST_FLALL: begin
                // walk from the top slot down, one slot a cycle while the output register takes each flush record
                if (rd_quads != '0) begin
                    if (out_free) begin
                        emit            = 1'b1;
                        e_kind          = K_FLUSH;
                        e_slot          = idx_slot;
                        e_key           = rd_key;
                        e_quads         = rd_a[QUAD_W-1:0];
                        e_last          = 1'b0;
                        wr_ctl.quads_en = 1'b1;
                        n_idx           = r_idx - 1'b1;
                        n_state         = (r_idx == '0) ? ST_DONE : ST_FLALL;
                    end
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = (r_idx == '0) ? ST_DONE : ST_FLALL;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = K_DONE;
                    n_state = ST_IDLE;
                end
            end

            ST_ERROR: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inj       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        if (in_accept) begin
            r_key <= in_key;
            r_qc  <= in_qc;
        end
        if (emit) begin
            r_out_data <= {{PAD_W{1'b0}}, e_vb, e_quads, e_key.flags, e_key.frame,
                           e_key.material, e_slot};
            r_out_kind <= e_kind;
            r_out_last <= e_last;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------------- checks
    ap_row_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_wave[0].live)
        else $error("search wave left the slot row while idle");

    ap_hit_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY && r_hit) |-> (rd_key == r_key))
        else $error("hit slot key differs from request key");

    ap_quads_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_ctl.quads_en |-> (AW'(wr_quads) <= AW'(MAX_QUADS)))
        else $error("slot quad count written above limit");

endmodule
